// ----- src/cascaded_biquad_filter_macros.svh -----
// Assertion macros shared by the filter's checker.
`ifndef CASCADED_BIQUAD_FILTER_MACROS_SVH
`define CASCADED_BIQUAD_FILTER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CBQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CBQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/cbq_pkg.sv -----
// Shared types and constants of the cascaded biquad filter.
`default_nettype none

package cbq_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int HIST_W       = 32;
    localparam int HIST_FRAC    = 24;
    localparam int COEF_W       = 32;
    localparam int COEF_FRAC    = 28;
    localparam int NTERMS       = 5;
    localparam int INDEX_W      = 6;
    localparam int CFG_W        = 4;
    localparam int SEC_W        = 4;
    localparam int TERM_W       = 3;
    localparam int PROD_W       = 2 * COEF_W;
    localparam int ACC_W        = PROD_W + 2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    localparam logic [TERM_W-1:0] TERM_B0 = 3'd0;
    localparam logic [TERM_W-1:0] TERM_B1 = 3'd1;
    localparam logic [TERM_W-1:0] TERM_B2 = 3'd2;
    localparam logic [TERM_W-1:0] TERM_A1 = 3'd3;
    localparam logic [TERM_W-1:0] TERM_A2 = 3'd4;

    typedef struct packed {
        logic                           kind;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           block_end_in;
        logic [INDEX_W-1:0]             coef_index;
        logic signed [COEF_W-1:0]       coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           clipped;
        logic                           block_end_out;
    } out_item_t;

    // Hand-off between neighboring sections.
    typedef struct packed {
        logic                     go;
        logic signed [HIST_W-1:0] v;
        logic signed [HIST_W-1:0] in1;
        logic signed [HIST_W-1:0] in2;
        logic                     clip;
    } link_t;

    // Coefficient write broadcast to all sections.
    typedef struct packed {
        logic                     en;
        logic [SEC_W-1:0]         section;
        logic [TERM_W-1:0]        term;
        logic signed [COEF_W-1:0] value;
    } coef_wr_t;

endpackage

`default_nettype wire

// ----- src/cbq_cell.sv -----
// One biquad section: coefficients, output history and a five-term MAC.
`default_nettype none

module cbq_cell #(
    parameter int SECTION_ID = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cbq_pkg::coef_wr_t coef_wr,
    input  cbq_pkg::link_t    link_in,
    output cbq_pkg::link_t    link_out
);
    import cbq_pkg::*;

    localparam int QW = ACC_W - COEF_FRAC;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);

    logic signed [COEF_W-1:0] coef_reg [NTERMS];
    logic signed [HIST_W-1:0] y1_reg, y2_reg;
    logic signed [HIST_W-1:0] i1_reg, i2_reg;
    logic                     clip_reg;
    logic [TERM_W-1:0]        term_reg, sel_term;
    logic                     issue_reg, prod_vld_reg, prod_last_reg, fin_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_rnd;
    logic [QW-1:0]            acc_q;
    logic signed [COEF_W-1:0] mul_a;
    logic signed [HIST_W-1:0] mul_b, sat_val;
    logic                     sat_hit;
    logic                     out_go_reg, out_clip_reg;
    logic signed [HIST_W-1:0] out_v_reg, out_i1_reg, out_i2_reg;

    assign sel_term = link_in.go ? TERM_B0 : term_reg;

    always_comb begin
        unique case (sel_term)
            TERM_B1: begin mul_a = coef_reg[1]; mul_b = i1_reg; end
            TERM_B2: begin mul_a = coef_reg[2]; mul_b = i2_reg; end
            TERM_A1: begin mul_a = coef_reg[3]; mul_b = y1_reg; end
            TERM_A2: begin mul_a = coef_reg[4]; mul_b = y2_reg; end
            default: begin mul_a = coef_reg[0]; mul_b = link_in.v; end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Round half up to 24 fraction bits, then clamp to 32 bits.
    assign acc_rnd = acc_reg + RND_HALF;
    assign acc_q   = acc_rnd[ACC_W-1:COEF_FRAC];
    assign sat_hit = !((&acc_q[QW-1:HIST_W-1]) || (~|acc_q[QW-1:HIST_W-1]));
    assign sat_val = sat_hit ? (acc_q[QW-1] ? {1'b1, {(HIST_W-1){1'b0}}}
                                            : {1'b0, {(HIST_W-1){1'b1}}})
                             : acc_q[HIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (coef_wr.en && (int'(coef_wr.section) == SECTION_ID)) begin
            coef_reg[coef_wr.term] <= coef_wr.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg     <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            fin_reg       <= 1'b0;
            out_go_reg    <= 1'b0;
            term_reg      <= TERM_B0;
            y1_reg        <= '0;
            y2_reg        <= '0;
        end else begin
            prod_reg      <= prod_next;
            prod_vld_reg  <= link_in.go || issue_reg;
            prod_last_reg <= issue_reg && (term_reg == TERM_A2);
            fin_reg       <= prod_vld_reg && prod_last_reg;

            if (link_in.go) begin
                i1_reg    <= link_in.in1;
                i2_reg    <= link_in.in2;
                clip_reg  <= link_in.clip;
                term_reg  <= TERM_B1;
                issue_reg <= 1'b1;
                acc_reg   <= '0;
            end else begin
                if (issue_reg) begin
                    if (term_reg == TERM_A2) begin
                        issue_reg <= 1'b0;
                    end else begin
                        term_reg <= term_reg + 3'd1;
                    end
                end
                if (prod_vld_reg) begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
            end

            out_go_reg <= fin_reg;
            if (fin_reg) begin
                out_v_reg    <= sat_val;
                out_clip_reg <= clip_reg || sat_hit;
                out_i1_reg   <= y1_reg;
                out_i2_reg   <= y2_reg;
                y2_reg       <= y1_reg;
                y1_reg       <= sat_val;
            end
        end
    end

    assign link_out = '{go:   out_go_reg,
                        v:    out_v_reg,
                        in1:  out_i1_reg,
                        in2:  out_i2_reg,
                        clip: out_clip_reg};

endmodule

`default_nettype wire

// ----- src/cascaded_biquad_filter.sv -----
// A sample blocks further input until its result has entered the output register,
//   with each section in use running its five-term MAC in turn; a coefficient
//   write leaves the input ready for the next item.
// The sections run one after another, so the section chain sets the sample rate.
// Reset (aresetn low, synchronous): clears all history words, the section count
//   and the handshake state; coefficients hold garbage until written.
`default_nettype none

module cascaded_biquad_filter #(
    parameter int NSECTIONS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [cbq_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  cbq_pkg::in_item_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output cbq_pkg::out_item_t       m_data
);
    import cbq_pkg::*;

    // Sample format conversion: Q1.(SW-1) into the 24-fraction-bit history word
    // and back. CW is wide enough for either direction without overflow.
    localparam int CW  = 40;
    localparam int ISH = (SAMPLE_WIDTH > HIST_FRAC + 1) ? SAMPLE_WIDTH - HIST_FRAC - 1 : 0;
    localparam int ILS = (SAMPLE_WIDTH < HIST_FRAC + 1) ? HIST_FRAC + 1 - SAMPLE_WIDTH : 0;
    localparam int OSH = ILS;
    localparam int OLS = ISH;
    localparam logic signed [CW-1:0] IRND = (ISH > 0) ? (CW'(1) <<< (ISH - 1)) : CW'(0);
    localparam logic signed [CW-1:0] ORND = (OSH > 0) ? (CW'(1) <<< (OSH - 1)) : CW'(0);
    localparam logic signed [CW-1:0] SMAX = (CW'(1) <<< (SAMPLE_WIDTH - 1)) - CW'(1);
    localparam logic signed [CW-1:0] SMIN = -SMAX - CW'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUSH
    } state_t;

    state_t                   state_reg;
    logic [CFG_W-1:0]         cfg_reg;
    logic [CFG_W-1:0]         n_eff;
    logic signed [HIST_W-1:0] x1_reg, x2_reg;
    logic                     blk_reg;
    out_item_t                res_reg;
    logic                     m_valid_reg;
    out_item_t                m_data_reg;

    logic                     s_xfer;
    logic signed [CW-1:0]     in_wide, out_wide;
    logic signed [HIST_W-1:0] v_conv;
    logic signed [SAMPLE_WIDTH-1:0] out_sat;
    logic                     out_clip;

    logic [2*INDEX_W-1:0]     sec_prod;
    logic [SEC_W-1:0]         coef_sec;
    logic [INDEX_W-1:0]       sec_base;
    coef_wr_t                 coef_wr;

    link_t                    head_link;
    link_t                    link_out_a [NSECTIONS];
    link_t                    fin_link;
    logic                     fin_hit;

    // Take a new item only when the chain is idle.
    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;

    // Sections beyond the built count are not there; clamp to NSECTIONS.
    assign n_eff = (int'(cfg_reg) > NSECTIONS) ? CFG_W'(NSECTIONS) : cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    // Input sample into the history format: exact shift for narrow samples,
    // round half up for wide ones.
    assign in_wide = ((CW'(s_data.sample_in) + IRND) >>> ISH) <<< ILS;
    assign v_conv  = in_wide[HIST_W-1:0];

    // Coefficient slot into section and term: section = index / 5 by the
    // reciprocal 13/64, exact over the whole 6-bit index range.
    assign sec_prod = (2*INDEX_W)'(s_data.coef_index) * (2*INDEX_W)'(13);
    assign coef_sec = sec_prod[INDEX_W+SEC_W-1:INDEX_W];
    assign sec_base = INDEX_W'(int'(coef_sec) * NTERMS);

    // Drop writes to slots past the last built section.
    assign coef_wr = '{en:      s_xfer && (s_data.kind == KIND_COEF)
                                && (int'(s_data.coef_index) < NTERMS * NSECTIONS),
                       section: coef_sec,
                       term:    TERM_W'(s_data.coef_index - sec_base),
                       value:   s_data.coef_value};

    // Feed the first section straight from the transfer; words 0 and 1 of the
    // history are the cascade input history.
    assign head_link = '{go:   s_xfer && (s_data.kind == KIND_SAMPLE) && (n_eff != '0),
                         v:    v_conv,
                         in1:  x1_reg,
                         in2:  x2_reg,
                         clip: 1'b0};

    for (genvar s = 0; s < NSECTIONS; s++) begin : g_cell
        link_t cell_in;
        link_t cell_out;

        if (s == 0) begin : g_head
            assign cell_in = head_link;
        end else begin : g_next
            // Advance to this section only when it is in use.
            always_comb begin
                cell_in    = link_out_a[s-1];
                cell_in.go = link_out_a[s-1].go && (int'(n_eff) > s);
            end
        end

        cbq_cell #(
            .SECTION_ID(s)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .coef_wr (coef_wr),
            .link_in (cell_in),
            .link_out(cell_out)
        );

        assign link_out_a[s] = cell_out;
    end

    // Pick the hand-off of the last section in use.
    always_comb begin
        fin_hit  = 1'b0;
        fin_link = '0;
        for (int s = 0; s < NSECTIONS; s++) begin
            if (link_out_a[s].go && (int'(n_eff) == s + 1)) begin
                fin_hit  = 1'b1;
                fin_link = link_out_a[s];
            end
        end
    end

    // Cascade output back to the sample format, round half up, then clamp.
    assign out_wide = ((CW'(fin_link.v) + ORND) >>> OSH) <<< OLS;
    assign out_clip = (out_wide > SMAX) || (out_wide < SMIN);
    assign out_sat  = (out_wide > SMAX) ? SAMPLE_WIDTH'(SMAX) :
                      (out_wide < SMIN) ? SAMPLE_WIDTH'(SMIN) :
                                          out_wide[SAMPLE_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            x1_reg      <= '0;
            x2_reg      <= '0;
        end else begin
            // Drop the output once its transfer completes, unless a new result
            // is pushed into the register in the same cycle.
            if (m_valid_reg && m_ready && (state_reg != ST_PUSH)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer && (s_data.kind == KIND_SAMPLE)) begin
                        // Input history advances even with no sections in use.
                        x2_reg  <= x1_reg;
                        x1_reg  <= v_conv;
                        blk_reg <= s_data.block_end_in;
                        if (n_eff == '0) begin
                            res_reg   <= '{sample_out:    s_data.sample_in,
                                           clipped:       1'b0,
                                           block_end_out: s_data.block_end_in};
                            state_reg <= ST_PUSH;
                        end else begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (fin_hit) begin
                        res_reg   <= '{sample_out:    out_sat,
                                       clipped:       fin_link.clip || out_clip,
                                       block_end_out: blk_reg};
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    // Hold the result until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- src/cbq_checker.sv -----
// Port-level checker for the cascaded biquad filter, with its bind.
`default_nettype none

module cbq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input cbq_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input cbq_pkg::out_item_t m_data
);
    import cbq_pkg::*;

`include "cascaded_biquad_filter_macros.svh"

    logic out_stall;
    logic in_sample;
    logic in_coef;

    assign out_stall = m_valid && !m_ready;
    assign in_sample = s_valid && s_ready && (s_data.kind == KIND_SAMPLE);
    assign in_coef   = s_valid && s_ready && (s_data.kind == KIND_COEF);

    `CBQ_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> m_valid && $stable(m_data), "result not held")
    `CBQ_ASSERT(a_sample_busy, aclk, aresetn, in_sample |=> !s_ready, "sample did not block input")
    `CBQ_ASSERT(a_coef_ready, aclk, aresetn, in_coef |=> s_ready, "coefficient blocked input")
    `CBQ_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind cascaded_biquad_filter cbq_checker u_cbq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_data   (s_data),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_data   (m_data)
);

`default_nettype wire

// ----- verif/cascaded_biquad_filter_checker.sv -----
// Result checker for the cascaded biquad filter: tracks its state, predicts and compares.
module cascaded_biquad_filter_checker #(
    parameter int NSECTIONS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [cbq_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  cbq_pkg::in_item_t         s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  cbq_pkg::out_item_t        m_data,
    output int                        error_count,
    output int                        pending_count
);
    import cbq_pkg::*;

    localparam int HIST_DEPTH = 2 * (NSECTIONS + 1);
    localparam int COEF_DEPTH = NTERMS * NSECTIONS;
    localparam int SUM_W      = ACC_W + 4;
    localparam int OUT_SHIFT  = HIST_FRAC + 1 - SAMPLE_WIDTH;
    localparam int COEF_HALF  = 1 << (COEF_FRAC - 1);
    localparam int OUT_HALF   = 1 << (OUT_SHIFT - 1);

    logic signed [HIST_W-1:0] history [HIST_DEPTH];
    logic signed [COEF_W-1:0] coefs [COEF_DEPTH];
    logic [CFG_W-1:0]         section_count;
    out_item_t                filtered_q [$];
    int                       mismatches = 0;

    function automatic logic signed [SUM_W-1:0] clamp(input logic signed [SUM_W-1:0] val,
                                                      input int w, output logic hit);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi  = (SUM_W'(1) << (w - 1)) - 1;
        lo  = -hi - 1;
        hit = 1'b0;
        if (val > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (val < lo) begin
            hit = 1'b1;
            return lo;
        end
        return val;
    endfunction

    function automatic logic signed [SUM_W-1:0] weigh(input logic signed [COEF_W-1:0] c,
                                                      input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] cw;
        cw = c;
        return cw * x;
    endfunction

    // Run one sample through the cascade and advance the history words.
    function automatic out_item_t filter_sample(input in_item_t item);
        out_item_t               res;
        logic signed [SUM_W-1:0] v, in1, in2, o1, o2, sum;
        logic                    clip, hit;
        int                      n, base;
        clip = 1'b0;
        v    = $signed(item.sample_in) <<< OUT_SHIFT;
        n    = (section_count > NSECTIONS) ? NSECTIONS : int'(section_count);
        in2  = history[0];
        in1  = history[1];
        history[0] = history[1];
        history[1] = v[HIST_W-1:0];
        for (int s = 0; s < n; s++) begin
            base = NTERMS * s;
            o2   = history[2 * s + 2];
            o1   = history[2 * s + 3];
            sum  = weigh(coefs[base + TERM_B0], v) + weigh(coefs[base + TERM_B1], in1)
                 + weigh(coefs[base + TERM_B2], in2) + weigh(coefs[base + TERM_A1], o1)
                 + weigh(coefs[base + TERM_A2], o2);
            sum  = (sum + COEF_HALF) >>> COEF_FRAC;
            v    = clamp(sum, HIST_W, hit);
            clip = clip | hit;
            history[2 * s + 2] = o1[HIST_W-1:0];
            history[2 * s + 3] = v[HIST_W-1:0];
            in1  = o1;
            in2  = o2;
        end
        if (n == 0) begin
            res.sample_out = item.sample_in;
        end else begin
            sum  = clamp((v + OUT_HALF) >>> OUT_SHIFT, SAMPLE_WIDTH, hit);
            clip = clip | hit;
            res.sample_out = sum[SAMPLE_WIDTH-1:0];
        end
        res.clipped       = clip;
        res.block_end_out = item.block_end_in;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            foreach (history[i]) history[i] = '0;
            section_count = '0;
            filtered_q.delete();
        end else begin
            if (cfg_we) section_count = cfg_wdata;
            // Compare before predicting so a new sample never meets its own result.
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: sample %0d clipped %0b end %0b",
                                 m_data.sample_out, m_data.clipped, m_data.block_end_out);
                    mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_data.sample_out !== want.sample_out ||
                        m_data.clipped !== want.clipped ||
                        m_data.block_end_out !== want.block_end_out) begin
                        if (mismatches < 10)
                            $display({"result mismatch: expected sample %0d clipped %0b end %0b,",
                                      " got sample %0d clipped %0b end %0b"},
                                     want.sample_out, want.clipped, want.block_end_out,
                                     m_data.sample_out, m_data.clipped, m_data.block_end_out);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.kind == KIND_COEF) begin
                    if (s_data.coef_index < COEF_DEPTH)
                        coefs[s_data.coef_index] = s_data.coef_value;
                end else begin
                    filtered_q.push_back(filter_sample(s_data));
                end
            end
        end
        error_count   <= mismatches;
        pending_count <= filtered_q.size();
    end

endmodule

// ----- verif/cascaded_biquad_filter_test.sv -----
// Testbench top for the cascaded biquad filter: stimulus, handshake pacing and verdict.
module cascaded_biquad_filter_test;
    import cbq_pkg::*;

    localparam int NSECTIONS       = 8;
    localparam int COEF_SLOTS      = NTERMS * NSECTIONS;
    // Settle beyond the longest sample latency, with every section in use.
    localparam int SETTLE          = 64;
    localparam int LONG_HOLD       = 240;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int NPHASES         = 12;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int ONE             = 1 << COEF_FRAC;      // 1.0 in Q4.28
    localparam int A1_LIM          = (ONE / 10) * 9;
    localparam int A2_LIM          = (ONE / 10) * 8;

    typedef enum {COEF_STABLE, COEF_WILD, COEF_EXTREME} coef_set_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;

    int error_count;
    int pending_count;
    int cycles;
    bit burst_mode;     // both sides run without idle cycles
    bit rx_long_hold;   // receiver inserts one long hold-off

    // Section counts per random phase: pass-through, full cascade and values above it.
    int phase_sections [NPHASES] = '{1, 8, 15, 2, 5, 0, 3, 12, 7, 4, 8, 6};

    cascaded_biquad_filter #(
        .NSECTIONS(NSECTIONS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    cascaded_biquad_filter_checker #(
        .NSECTIONS(NSECTIONS)
    ) filter_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("cascaded_biquad_filter_test: done, errors");
        $finish;
    end

    function automatic int draw_gap();
        return burst_mode ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic in_item_t compose(input logic kind, input logic [SAMPLE_WIDTH-1:0] sample,
                                         input logic block_end, input logic [INDEX_W-1:0] index,
                                         input logic [COEF_W-1:0] value);
        in_item_t item;
        item.kind         = kind;
        item.sample_in    = sample;
        item.block_end_in = block_end;
        item.coef_index   = index;
        item.coef_value   = value;
        return item;
    endfunction

    // Coefficient inside the stability triangle: |a1| < 1 - a2 with a2 in [-0.8, 0].
    function automatic logic [COEF_W-1:0] stable_coef(input int term);
        case (term)
            TERM_A1: return $urandom_range(0, 2 * A1_LIM) - A1_LIM;
            TERM_A2: return -int'($urandom_range(0, A2_LIM));
            default: return $urandom_range(0, ONE) - ONE / 2;
        endcase
    endfunction

    // Offer one item after a random gap; hold valid and payload until the transfer.
    task automatic offer(input in_item_t item);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid, wait for every predicted result, then let the chain settle.
    task automatic pause_until_drained();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_sections(input logic [CFG_W-1:0] count);
        pause_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // Load every slot of every section; side fields carry random junk.
    task automatic load_coefficients(input coef_set_t set);
        logic [COEF_W-1:0] value;
        for (int i = 0; i < COEF_SLOTS; i++) begin
            case (set)
                COEF_STABLE: value = stable_coef(i % NTERMS);
                COEF_WILD:   value = $urandom;
                default: begin
                    if (i % NTERMS == TERM_B0)
                        value = 32'h8000_0000;      // -8.0
                    else if (i % NTERMS == TERM_B1)
                        value = 32'h7FFF_FFFF;      // just under +8.0
                    else
                        value = '0;
                end
            endcase
            offer(compose(KIND_COEF, SAMPLE_WIDTH'($urandom), 1'($urandom_range(0, 1)),
                          INDEX_W'(i), value));
        end
    endtask

    // Receiver: idle a random count before each result, with one long hold-off on request.
    initial begin
        int hold;
        bit long_done;
        m_ready   = 1'b0;
        long_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_long_hold && !long_done) begin
                hold      = LONG_HOLD;
                long_done = 1'b1;
            end else begin
                hold = draw_gap();
            end
            if (hold > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Stimulus.
    initial begin
        in_item_t item;
        int       pick;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        burst_mode   = 1'b0;
        rx_long_hold = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Zero sections after reset: samples pass through; hit the sample extremes.
        offer(compose(KIND_SAMPLE, 24'h7F_FFFF, 1'b1, '0, '0));
        offer(compose(KIND_SAMPLE, 24'h80_0000, 1'b0, '0, '0));
        offer(compose(KIND_SAMPLE, 24'h00_0000, 1'b1, 6'h3F, 32'hFFFF_FFFF));
        offer(compose(KIND_SAMPLE, 24'hFF_FFFF, 1'b0, '0, '0));

        // Extreme coefficients everywhere, then writes past the last slot that must be dropped.
        load_coefficients(COEF_EXTREME);
        offer(compose(KIND_COEF, '0, 1'b1, 6'd40, 32'h1234_5678));
        offer(compose(KIND_COEF, 24'hFF_FFFF, 1'b1, 6'h3F, 32'hFFFF_FFFF));

        // Full cascade with b0 = -8.0 and b1 just under +8.0 per section: history words saturate.
        write_sections(CFG_W'(8));
        offer(compose(KIND_SAMPLE, 24'h7F_FFFF, 1'b0, '0, '0));
        offer(compose(KIND_SAMPLE, 24'h7F_FFFF, 1'b0, '0, '0));
        offer(compose(KIND_SAMPLE, 24'h80_0000, 1'b1, '0, '0));
        offer(compose(KIND_SAMPLE, 24'h00_0000, 1'b0, '0, '0));

        // One section: only the output conversion saturates.
        write_sections(CFG_W'(1));
        offer(compose(KIND_SAMPLE, 24'h7F_FFFF, 1'b0, '0, '0));
        offer(compose(KIND_SAMPLE, 24'h80_0000, 1'b0, '0, '0));
        offer(compose(KIND_SAMPLE, 24'h00_0001, 1'b1, '0, '0));

        // Random phases: mostly well-behaved filters fed random audio.
        for (int p = 0; p < NPHASES; p++) begin
            write_sections(CFG_W'(phase_sections[p]));
            if (p == 3 || p == 7)
                load_coefficients(COEF_WILD);
            else if (p % 4 == 0)
                load_coefficients(COEF_STABLE);
            burst_mode = (p % 3 == 2);
            // Hold the receiver off while the sender keeps offering, to stall the input.
            if (p == 1) rx_long_hold = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick      = $urandom_range(0, 99);
                item      = {$urandom, $urandom};
                item.kind = KIND_SAMPLE;
                if (pick < 12)
                    item.sample_in = SAMPLE_WIDTH'($urandom_range(0, 511) - 256);
                if (pick >= 86 && pick < 94) begin
                    // Retune one in-range slot mid-stream.
                    item.kind       = KIND_COEF;
                    item.coef_index = INDEX_W'($urandom_range(0, COEF_SLOTS - 1));
                    item.coef_value = stable_coef(item.coef_index % NTERMS);
                end else if (pick >= 94) begin
                    // Raw write: any slot, any value, including ignored slots.
                    item.kind = KIND_COEF;
                end
                offer(item);
            end
            burst_mode = 1'b0;
        end

        pause_until_drained();
        if (error_count == 0 && pending_count == 0)
            $display("cascaded_biquad_filter_test: done, clean");
        else
            $display("cascaded_biquad_filter_test: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/cbq_pkg.sv
src/cbq_cell.sv
src/cascaded_biquad_filter.sv
src/cbq_checker.sv
verif/cascaded_biquad_filter_checker.sv
verif/cascaded_biquad_filter_test.sv
